// File: src/mgds_pkg.sv
// Shared types and constants for the global duty sweep controller.
// Holds the beat structs, field widths, register map and reset values.
// No dependencies.
package mgds_pkg;

    // Field widths.
    localparam int ADC_BITS    = 12;
    localparam int DUTY_BITS   = 16;
    localparam int POWER_BITS  = 2 * ADC_BITS;
    localparam int ENERGY_BITS = 28;
    localparam int TICK_BITS   = 16;

    // Default ratio between the sweep period and one tick.
    localparam int PERIOD_RATIO_DEFAULT = 10;

    // Configuration port geometry.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // Register indexes.
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_STEP    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP_COUNT   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TRACK_ENABLE = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FIXED_DUTY   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_FLOOR   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_CEILING = 3'd5;

    // Register reset values.
    localparam logic [DUTY_BITS-1:0] RST_DUTY_STEP    = 16'd655;
    localparam logic [TICK_BITS-1:0] RST_STEP_COUNT   = 16'd100;
    localparam logic                 RST_TRACK_ENABLE = 1'b1;
    localparam logic [DUTY_BITS-1:0] RST_FIXED_DUTY   = 16'd32768;
    localparam logic [DUTY_BITS-1:0] RST_DUTY_FLOOR   = 16'd0;
    localparam logic [DUTY_BITS-1:0] RST_DUTY_CEILING = 16'hFFFF;

    // Input opcodes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Sweep modes.
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DONE   = 2'd2;

    // Input beat.
    typedef struct packed {
        logic                opcode;
        logic [ADC_BITS-1:0] voltage_sample;
        logic [ADC_BITS-1:0] current_sample;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [DUTY_BITS-1:0]   duty_command;
        logic                   search_done;
        logic [POWER_BITS-1:0]  measured_power;
        logic [POWER_BITS-1:0]  peak_power;
        logic [ENERGY_BITS-1:0] energy_estimate;
    } out_beat_t;

endpackage

// File: src/mppt_global_duty_sweep_unit.sv
// Global duty sweep maximum-power-point controller, top level.
// Depends on mgds_pkg for beat types, register map and constants.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | sink      | in_valid / in_stall | opcode, voltage and current
//  out      | source    | out_valid/out_stall | duty, done, power, peak, energy
//  config   | APB slave | psel/penable/pready | six registers at 4*index
//
// An accepted beat passes the input register; a tick then goes through the multiply,
// compare and duty update into the result register, while a restart only resets the sweep.
// One beat is accepted per cycle when the output is not stalled.
// Reset clears the pipeline valids and the sweep state and loads the register reset values.
// A stalled result holds; the input register still fills behind it.
module mppt_global_duty_sweep_unit #(
    parameter int PERIOD_RATIO = mgds_pkg::PERIOD_RATIO_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mgds_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mgds_pkg::out_beat_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mgds_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mgds_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mgds_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import mgds_pkg::*;

    localparam int RATIO_BITS = $clog2(PERIOD_RATIO + 1);
    localparam int PROD_A     = POWER_BITS + RATIO_BITS;
    localparam int PROD_B     = ENERGY_BITS + 1;
    localparam int PROD_BITS  = (PROD_A > PROD_B) ? PROD_A : PROD_B;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = {ENERGY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0]   DUTY_FULL  = {DUTY_BITS{1'b1}};
    localparam logic [TICK_BITS-1:0]   TICK_MAX   = {TICK_BITS{1'b1}};

    // Configuration registers.
    logic [DUTY_BITS-1:0] duty_step_reg;
    logic [TICK_BITS-1:0] step_count_reg;
    logic                 track_enable_reg;
    logic [DUTY_BITS-1:0] fixed_duty_reg;
    logic [DUTY_BITS-1:0] duty_floor_reg;
    logic [DUTY_BITS-1:0] duty_ceiling_reg;

    // Pipeline registers.
    logic      s1_valid_reg;
    in_beat_t  s1_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;

    // Sweep state.
    logic [1:0]             sweep_mode_reg,   sweep_mode_next;
    logic [DUTY_BITS-1:0]   duty_level_reg,   duty_level_next;
    logic [DUTY_BITS-1:0]   best_duty_reg,    best_duty_next;
    logic [POWER_BITS-1:0]  max_power_reg,    max_power_next;
    logic [TICK_BITS-1:0]   tick_count_reg,   tick_count_next;
    logic [ENERGY_BITS-1:0] energy_value_reg, energy_value_next;

    logic                   cfg_write;
    logic [REG_IDX_BITS-1:0] cfg_idx;
    logic                   out_free;
    logic                   s1_fire;
    logic                   s1_tick;
    logic [POWER_BITS-1:0]  power;
    logic [DUTY_BITS:0]     duty_sum;
    logic [PROD_BITS-1:0]   energy_prod;
    logic [DUTY_BITS-1:0]   duty_clamped;
    out_beat_t              result;

    // Configuration port decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_step_reg    <= RST_DUTY_STEP;
            step_count_reg   <= RST_STEP_COUNT;
            track_enable_reg <= RST_TRACK_ENABLE;
            fixed_duty_reg   <= RST_FIXED_DUTY;
            duty_floor_reg   <= RST_DUTY_FLOOR;
            duty_ceiling_reg <= RST_DUTY_CEILING;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_DUTY_STEP:    duty_step_reg    <= pwdata[DUTY_BITS-1:0];
                REG_STEP_COUNT:   step_count_reg   <= pwdata[TICK_BITS-1:0];
                REG_TRACK_ENABLE: track_enable_reg <= pwdata[0];
                REG_FIXED_DUTY:   fixed_duty_reg   <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_FLOOR:   duty_floor_reg   <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_CEILING: duty_ceiling_reg <= pwdata[DUTY_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            REG_DUTY_STEP:    prdata = APB_DATA_BITS'(duty_step_reg);
            REG_STEP_COUNT:   prdata = APB_DATA_BITS'(step_count_reg);
            REG_TRACK_ENABLE: prdata = APB_DATA_BITS'(track_enable_reg);
            REG_FIXED_DUTY:   prdata = APB_DATA_BITS'(fixed_duty_reg);
            REG_DUTY_FLOOR:   prdata = APB_DATA_BITS'(duty_floor_reg);
            REG_DUTY_CEILING: prdata = APB_DATA_BITS'(duty_ceiling_reg);
            default:          prdata = '0;
        endcase
    end

    // Flow control: a restart beat leaves without a result, a tick needs
    // the result register to be free or draining this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_tick  = (s1_data_reg.opcode == OP_TICK);
    assign s1_fire  = s1_valid_reg && (!s1_tick || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Power, duty increment and energy estimate.
    assign power       = POWER_BITS'(s1_data_reg.voltage_sample)
                       * POWER_BITS'(s1_data_reg.current_sample);
    assign duty_sum    = {1'b0, duty_level_reg} + {1'b0, duty_step_reg};
    assign energy_prod = PROD_BITS'(max_power_reg) * PROD_BITS'(PERIOD_RATIO);

    // Sweep state update for one tick.
    always_comb
    begin
        sweep_mode_next   = sweep_mode_reg;
        duty_level_next   = duty_level_reg;
        best_duty_next    = best_duty_reg;
        max_power_next    = max_power_reg;
        tick_count_next   = tick_count_reg;
        energy_value_next = energy_value_reg;

        unique case (sweep_mode_reg)
            MODE_INIT:
            begin
                tick_count_next   = '0;
                duty_level_next   = duty_step_reg;
                max_power_next    = '0;
                best_duty_next    = '0;
                energy_value_next = '0;
                sweep_mode_next   = MODE_SEARCH;
            end
            MODE_SEARCH:
            begin
                if (tick_count_reg < step_count_reg)
                begin
                    if (power > max_power_reg)
                    begin
                        max_power_next = power;
                        best_duty_next = duty_level_reg;
                    end
                    duty_level_next = duty_sum[DUTY_BITS] ? DUTY_FULL
                                                          : duty_sum[DUTY_BITS-1:0];
                end
                else
                begin
                    sweep_mode_next   = MODE_DONE;
                    duty_level_next   = best_duty_reg;
                    energy_value_next = (energy_prod > PROD_BITS'(ENERGY_MAX))
                                      ? ENERGY_MAX : energy_prod[ENERGY_BITS-1:0];
                end
            end
            MODE_DONE:
            begin
            end
            default:
            begin
                sweep_mode_next = MODE_INIT;
            end
        endcase

        if (!track_enable_reg)
        begin
            duty_level_next = fixed_duty_reg;
        end

        if (tick_count_next != TICK_MAX)
        begin
            tick_count_next = tick_count_next + 1'b1;
        end
    end

    // Clamp the driven duty: ceiling first, then floor.
    always_comb
    begin
        if (duty_level_next >= duty_ceiling_reg)
        begin
            duty_clamped = duty_ceiling_reg;
        end
        else if (duty_level_next <= duty_floor_reg)
        begin
            duty_clamped = duty_floor_reg;
        end
        else
        begin
            duty_clamped = duty_level_next;
        end
    end

    // Result beat.
    always_comb
    begin
        result.duty_command    = duty_clamped;
        result.search_done     = (sweep_mode_next == MODE_DONE);
        result.measured_power  = power;
        result.peak_power      = max_power_next;
        result.energy_estimate = energy_value_next;
    end

    // Sweep state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_mode_reg   <= MODE_INIT;
            duty_level_reg   <= '0;
            best_duty_reg    <= '0;
            max_power_reg    <= '0;
            tick_count_reg   <= '0;
            energy_value_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_tick)
            begin
                sweep_mode_reg   <= sweep_mode_next;
                duty_level_reg   <= duty_level_next;
                best_duty_reg    <= best_duty_next;
                max_power_reg    <= max_power_next;
                tick_count_reg   <= tick_count_next;
                energy_value_reg <= energy_value_next;
            end
            else
            begin
                sweep_mode_reg <= MODE_INIT;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_tick)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A finished sweep holds the saturated energy of its peak.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_mode_reg == MODE_DONE) |->
            (energy_value_reg == ((energy_prod > PROD_BITS'(ENERGY_MAX))
                                  ? ENERGY_MAX : energy_prod[ENERGY_BITS-1:0])))
        else $error("energy estimate does not match peak power in DONE");

    // The input only stalls behind a held beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    // A driven duty lies between floor and ceiling when they are ordered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (duty_floor_reg <= duty_ceiling_reg)) |->
            ((out_data_reg.duty_command >= duty_floor_reg)
             && (out_data_reg.duty_command <= duty_ceiling_reg)))
        else $error("duty command outside floor and ceiling");

    // A tick accepted into the result register leaves the sweep out of INIT.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_tick) |=> (sweep_mode_reg != MODE_INIT)
                                 || (($past(sweep_mode_reg) != MODE_INIT)
                                     && ($past(sweep_mode_reg) != MODE_SEARCH)
                                     && ($past(sweep_mode_reg) != MODE_DONE)))
        else $error("tick left the sweep in INIT");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the global duty sweep controller (mppt_global_duty_sweep_unit).
// A directed plan, then randomized phases under varied register settings and flow control.
// Depends on mgds_pkg and the controller RTL.
module testbench;
    import mgds_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 16;
    localparam int BEATS_PER_PHASE = 50;
    localparam int MAX_REPORTS     = 10;

    // One row of the directed plan: either a beat or a register write.
    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;
    typedef struct packed {
        row_kind_t               kind;
        in_beat_t                beat;
        logic                    known;
        out_beat_t               want;
        logic [REG_IDX_BITS-1:0] reg_idx;
        logic [31:0]             reg_val;
    } plan_row_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    in_beat_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_beat_t                out_data;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr     = '0;
    logic [APB_DATA_BITS-1:0] pwdata    = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Sweep state and register copies kept by the predictor.
    logic [1:0]  sweep_state;
    logic [15:0] duty_now;
    logic [15:0] duty_best;
    logic [23:0] power_peak;
    logic [15:0] tick_total;
    logic [27:0] energy_now;
    logic [15:0] cfg_step;
    logic [15:0] cfg_count;
    logic        cfg_track;
    logic [15:0] cfg_fixed;
    logic [15:0] cfg_floor;
    logic [15:0] cfg_ceiling;

    plan_row_t   plan[$];
    out_beat_t   pending_results[$];
    out_beat_t   head_result;
    int          error_count   = 0;
    int          beats_sent    = 0;
    int          results_seen  = 0;
    int          done_seen     = 0;
    int          settings_used = 0;
    int          cycle_count   = 0;
    int          send_gap_pct  = 0;
    int          stall_pct     = 0;

    mppt_global_duty_sweep_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that takes far longer than the slowest correct one has hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // Result side: every accepted beat is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (out_data.search_done)
                done_seen++;
            if (pending_results.size() == 0)
                flag_error("result beat with no expectation pending");
            else
            begin
                head_result = pending_results.pop_front();
                check_field("duty_command", 32'(head_result.duty_command),
                            32'(out_data.duty_command));
                check_field("search_done", 32'(head_result.search_done),
                            32'(out_data.search_done));
                check_field("measured_power", 32'(head_result.measured_power),
                            32'(out_data.measured_power));
                check_field("peak_power", 32'(head_result.peak_power),
                            32'(out_data.peak_power));
                check_field("energy_estimate", 32'(head_result.energy_estimate),
                            32'(out_data.energy_estimate));
            end
        end
    end

    function automatic void reset_predictor();
        sweep_state = MODE_INIT;
        duty_now    = '0;
        duty_best   = '0;
        power_peak  = '0;
        tick_total  = '0;
        energy_now  = '0;
        cfg_step    = RST_DUTY_STEP;
        cfg_count   = RST_STEP_COUNT;
        cfg_track   = RST_TRACK_ENABLE;
        cfg_fixed   = RST_FIXED_DUTY;
        cfg_floor   = RST_DUTY_FLOOR;
        cfg_ceiling = RST_DUTY_CEILING;
    endfunction

    // Advances the sweep by one input beat; returns 1 when the beat yields a result.
    function automatic logic predict_sweep(input in_beat_t b, output out_beat_t r);
        logic [23:0] pw;
        logic [16:0] sum;
        logic [31:0] scaled;
        r = '0;
        if (b.opcode == OP_RESTART)
        begin
            sweep_state = MODE_INIT;
            return 1'b0;
        end
        pw = 24'(b.voltage_sample) * 24'(b.current_sample);
        case (sweep_state)
            MODE_INIT:
            begin
                tick_total  = '0;
                duty_now    = cfg_step;
                power_peak  = '0;
                duty_best   = '0;
                energy_now  = '0;
                sweep_state = MODE_SEARCH;
            end
            MODE_SEARCH:
            begin
                if (tick_total < cfg_count)
                begin
                    if (pw > power_peak)
                    begin
                        power_peak = pw;
                        duty_best  = duty_now;
                    end
                    sum      = {1'b0, duty_now} + {1'b0, cfg_step};
                    duty_now = sum[16] ? 16'hFFFF : sum[15:0];
                end
                else
                begin
                    sweep_state = MODE_DONE;
                    duty_now    = duty_best;
                    scaled      = 32'(power_peak) * 32'(PERIOD_RATIO_DEFAULT);
                    energy_now  = (scaled > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : scaled[27:0];
                end
            end
            MODE_DONE: ;
            default: sweep_state = MODE_INIT;
        endcase
        if (!cfg_track)
            duty_now = cfg_fixed;
        if (tick_total != 16'hFFFF)
            tick_total++;
        // The ceiling test comes first, so in an inverted window a duty at or above the ceiling drives the ceiling.
        if (duty_now >= cfg_ceiling)
            r.duty_command = cfg_ceiling;
        else if (duty_now <= cfg_floor)
            r.duty_command = cfg_floor;
        else
            r.duty_command = duty_now;
        r.search_done     = (sweep_state == MODE_DONE);
        r.measured_power  = pw;
        r.peak_power      = power_peak;
        r.energy_estimate = energy_now;
        return 1'b1;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_BITS-1:0] idx,
                                           input logic [31:0] val);
        case (idx)
            REG_DUTY_STEP:    cfg_step    = val[15:0];
            REG_STEP_COUNT:   cfg_count   = val[15:0];
            REG_TRACK_ENABLE: cfg_track   = val[0];
            REG_FIXED_DUTY:   cfg_fixed   = val[15:0];
            REG_DUTY_FLOOR:   cfg_floor   = val[15:0];
            REG_DUTY_CEILING: cfg_ceiling = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [REG_IDX_BITS-1:0] idx);
        case (idx)
            REG_DUTY_STEP:    return {16'd0, cfg_step};
            REG_STEP_COUNT:   return {16'd0, cfg_count};
            REG_TRACK_ENABLE: return {31'd0, cfg_track};
            REG_FIXED_DUTY:   return {16'd0, cfg_fixed};
            REG_DUTY_FLOOR:   return {16'd0, cfg_floor};
            REG_DUTY_CEILING: return {16'd0, cfg_ceiling};
            default:          return '0;
        endcase
    endfunction

    // Directed plan builders.
    function automatic void row_tick(input logic [11:0] v, input logic [11:0] c);
        plan_row_t row;
        row = '0;
        row.kind                = ROW_BEAT;
        row.beat.opcode         = OP_TICK;
        row.beat.voltage_sample = v;
        row.beat.current_sample = c;
        plan.push_back(row);
    endfunction

    function automatic void row_known(input logic [11:0] v, input logic [11:0] c,
                                      input logic [15:0] duty, input logic done,
                                      input logic [23:0] pw, input logic [23:0] pk,
                                      input logic [27:0] en);
        plan_row_t row;
        row = '0;
        row.kind                 = ROW_BEAT;
        row.beat.opcode          = OP_TICK;
        row.beat.voltage_sample  = v;
        row.beat.current_sample  = c;
        row.known                = 1'b1;
        row.want.duty_command    = duty;
        row.want.search_done     = done;
        row.want.measured_power  = pw;
        row.want.peak_power      = pk;
        row.want.energy_estimate = en;
        plan.push_back(row);
    endfunction

    function automatic void row_restart();
        plan_row_t row;
        row = '0;
        row.kind                = ROW_BEAT;
        row.beat.opcode         = OP_RESTART;
        row.beat.voltage_sample = 12'hFFF;
        row.beat.current_sample = 12'hFFF;
        plan.push_back(row);
    endfunction

    function automatic void row_reg(input logic [REG_IDX_BITS-1:0] idx,
                                    input logic [31:0] val);
        plan_row_t row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(9))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [15:0] pick_duty(input int hi);
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(hi));
        endcase
    endfunction

    // Offers one beat, holds it through stalls, and records what it should produce.
    // Entered and left at a falling edge; valid stays high for a following beat.
    task automatic send_beat(input in_beat_t b, input logic known, input out_beat_t want);
        out_beat_t r;
        logic      has_result;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has_result = predict_sweep(b, r);
        if (has_result)
            pending_results.push_back(known ? want : r);
        beats_sent++;
        @(negedge clk);
    endtask

    // Stops sending, lets every pending result drain, then holds the input idle so that a
    // restart still in flight, which has no result to wait for, also leaves the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One APB transfer: setup phase, then access until pready.
    task automatic reg_access(input logic wr, input logic [REG_IDX_BITS-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes a register, mirrors it in the predictor, and reads it back.
    task automatic write_register(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        reg_access(1'b1, idx, val, rd);
        apply_register(idx, val);
        reg_access(1'b0, idx, '0, rd);
        check_field($sformatf("register %0d readback", idx), register_value(idx), rd);
    endtask

    initial
    begin
        in_beat_t  b;
        logic [15:0] lo;
        logic [15:0] hi;

        reset_predictor();

        // Directed plan. Typed expectations follow reset defaults and the extremes.
        row_known(12'd4095, 12'd4095, 16'd655, 1'b0, 24'd16769025, 24'd0, 28'd0);
        row_known(12'd4095, 12'd4095, 16'd1310, 1'b0, 24'd16769025, 24'd16769025, 28'd0);
        row_known(12'd0, 12'd0, 16'd1965, 1'b0, 24'd0, 24'd16769025, 28'd0);
        row_restart();
        row_known(12'd1, 12'd4095, 16'd655, 1'b0, 24'd4095, 24'd0, 28'd0);
        // Short sweep with the largest step: duty saturates at full scale.
        row_reg(REG_STEP_COUNT, 32'd2);
        row_reg(REG_DUTY_STEP, 32'd65535);
        row_restart();
        row_known(12'd100, 12'd100, 16'd65535, 1'b0, 24'd10000, 24'd0, 28'd0);
        row_known(12'd200, 12'd100, 16'd65535, 1'b0, 24'd20000, 24'd20000, 28'd0);
        row_known(12'd7, 12'd7, 16'd65535, 1'b1, 24'd49, 24'd20000, 28'd200000);
        row_known(12'd4095, 12'd4095, 16'd65535, 1'b1, 24'd16769025, 24'd20000, 28'd200000);
        // Tracking off forces the fixed duty.
        row_reg(REG_TRACK_ENABLE, 32'd0);
        row_reg(REG_FIXED_DUTY, 32'd12345);
        row_known(12'd3, 12'd5, 16'd12345, 1'b1, 24'd15, 24'd20000, 28'd200000);
        // Floor above ceiling: the ceiling wins for high duty, the floor for low duty.
        row_reg(REG_DUTY_FLOOR, 32'd20000);
        row_reg(REG_DUTY_CEILING, 32'd10000);
        row_known(12'd0, 12'd4095, 16'd10000, 1'b1, 24'd0, 24'd20000, 28'd200000);
        row_reg(REG_FIXED_DUTY, 32'd0);
        row_known(12'd4095, 12'd0, 16'd20000, 1'b1, 24'd0, 24'd20000, 28'd200000);
        // Zero step count and zero step: the sweep ends on its first search tick.
        row_reg(REG_DUTY_FLOOR, 32'd0);
        row_reg(REG_DUTY_CEILING, 32'd65535);
        row_reg(REG_TRACK_ENABLE, 32'd1);
        row_reg(REG_STEP_COUNT, 32'd0);
        row_reg(REG_DUTY_STEP, 32'd0);
        row_restart();
        row_known(12'd12, 12'd34, 16'd0, 1'b0, 24'd408, 24'd0, 28'd0);
        row_known(12'd2048, 12'd2048, 16'd0, 1'b1, 24'd4194304, 24'd0, 28'd0);
        row_tick(12'd2730, 12'd1365);
        // Longest sweep with the smallest nonzero step.
        row_reg(REG_STEP_COUNT, 32'd65535);
        row_reg(REG_DUTY_STEP, 32'd1);
        row_restart();
        row_known(12'd4095, 12'd4094, 16'd1, 1'b0, 24'd16764930, 24'd0, 28'd0);
        row_known(12'd2, 12'd3, 16'd2, 1'b0, 24'd6, 24'd6, 28'd0);
        row_tick(12'd1365, 12'd2730);
        row_tick(12'd4000, 12'd4000);

        // Reset is held from the start and released at a falling edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_gap_pct = 11;
        stall_pct    = 11;
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_REG)
            begin
                settle();
                write_register(plan[k].reg_idx, plan[k].reg_val);
                settings_used++;
            end
            else
                send_beat(plan[k].beat, plan[k].known, plan[k].want);
        end

        // Random phases: new register settings each time, then mostly well-formed
        // sweeps (restart followed by ticks) with random samples.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            write_register(REG_DUTY_STEP, {16'd0, pick_duty(8000)});
            if (p == 3)
                write_register(REG_STEP_COUNT, 32'd65535);
            else if (p == 5)
                write_register(REG_STEP_COUNT, 32'd0);
            else
                write_register(REG_STEP_COUNT, $urandom_range(1, 12));
            write_register(REG_TRACK_ENABLE, ($urandom_range(4) != 0) ? 32'd1 : 32'd0);
            write_register(REG_FIXED_DUTY, {16'd0, pick_duty(65535)});
            if (p == 1)
            begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            else if (p == 6)
            begin
                lo = 16'hFFFF;
                hi = 16'd0;
            end
            else if (p % 5 == 2)
            begin
                lo = 16'($urandom_range(32768, 65535));
                hi = 16'($urandom_range(0, 32767));
            end
            else
            begin
                lo = 16'($urandom_range(0, 16000));
                hi = 16'($urandom_range(48000, 65535));
            end
            write_register(REG_DUTY_FLOOR, {16'd0, lo});
            write_register(REG_DUTY_CEILING, {16'd0, hi});
            settings_used++;

            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 88;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 88;
                end
                default:
                begin
                    send_gap_pct = 11;
                    stall_pct    = 11;
                end
            endcase

            b = '0;
            b.opcode = OP_RESTART;
            send_beat(b, 1'b0, '0);
            for (int n = 1; n < BEATS_PER_PHASE; n++)
            begin
                b.opcode         = ($urandom_range(99) < 6) ? OP_RESTART : OP_TICK;
                b.voltage_sample = pick_sample();
                b.current_sample = pick_sample();
                send_beat(b, 1'b0, '0);
            end
        end

        // Let the last results arrive, then wait out anything stray.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d input beats under %0d register settings; checked %0d results,",
                 beats_sent, settings_used, results_seen);
        $display("%0d of them after a finished sweep, with %0d errors.",
                 done_seen, error_count);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: mppt_global_duty_sweep_unit.f
src/mgds_pkg.sv
src/mppt_global_duty_sweep_unit.sv
bench/testbench.sv
